FILE: design/cflw_pkg.sv
// ----------------------------------------------------------------------------
// Circular flash log writer package
// Shared widths, codes and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package cflw_pkg;

   localparam int BYTE_W  = 8;
   localparam int SEC_W   = 12;
   localparam int SPAGE_W = 4;
   localparam int ADDR_W  = 24;
   localparam int DATA_W  = 64;
   localparam int IDX_W   = 8;

   // Newline character: closes a page when it ends a string.
   localparam logic [BYTE_W-1:0] NL_CHAR = 8'h0A;

   // Result command codes.
   localparam logic CMD_PROGRAM = 1'b0;
   localparam logic CMD_ERASE   = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [IDX_W-1:0] CSR_FIRST_SECTOR = 8'd0;
   localparam logic [IDX_W-1:0] CSR_LAST_SECTOR  = 8'd1;
   localparam logic [IDX_W-1:0] CSR_START_SECTOR = 8'd2;
   localparam logic [IDX_W-1:0] CSR_START_PAGE   = 8'd3;

   typedef struct packed {
      logic accept;      // take the input beat and store its byte
      logic load_base;   // latch the page base address, clear the word counter
      logic emit_word;   // load one program word into the output register
      logic adv_sector;  // step the sector pointer round the ring
      logic emit_erase;  // load the erase command into the output register
   } cflw_cmd_type;

   typedef struct packed {
      logic flush;       // the beat on offer closes the page
      logic slot_free;   // output register can take a new beat
      logic last_word;   // word counter is on the last word of the page
      logic page_wrap;   // advancing the page pointer wraps the sector
   } cflw_stat_type;

endpackage

FILE: design/cflw_if.sv
// ----------------------------------------------------------------------------
// Circular flash log writer channels
// Valid/ready channels for log bytes, flash commands and register writes.
// ----------------------------------------------------------------------------
interface cflw_req_if import cflw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              string_end;

   modport source (output valid, output text_byte, output string_end, input ready);
   modport sink   (input valid, input text_byte, input string_end, output ready);
endinterface

interface cflw_rsp_if import cflw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              command;
   logic [ADDR_W-1:0] flash_address;
   logic [DATA_W-1:0] data_word;
   logic              final_result;

   modport source (output valid, output command, output flash_address,
                   output data_word, output final_result, input ready);
   modport sink   (input valid, input command, input flash_address,
                   input data_word, input final_result, output ready);
endinterface

interface cflw_csr_if import cflw_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [SEC_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/cflw_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cflw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/cflw_ctrl.sv
// ----------------------------------------------------------------------------
// Circular flash log writer controller
// Sequences byte intake, page flush word by word and the sector erase.
// ----------------------------------------------------------------------------
module cflw_ctrl import cflw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  cflw_stat_type stat,
   output cflw_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_BASE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EMIT  = 3'd3;
   localparam logic [2:0] S_ADV   = 3'd4;
   localparam logic [2:0] S_ERASE = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.flush) begin
                  state_in = S_BASE;
               end
            end
         end
         S_BASE: begin
            cmd.load_base = 1'b1;
            state_in      = S_READ;
         end
         S_READ: begin
            // Page RAM read of the current word is in flight.
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.slot_free) begin
               cmd.emit_word = 1'b1;
               if (!stat.last_word) begin
                  state_in = S_READ;
               end else if (stat.page_wrap) begin
                  state_in = S_ADV;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_ADV: begin
            cmd.adv_sector = 1'b1;
            state_in       = S_ERASE;
         end
         S_ERASE: begin
            if (stat.slot_free) begin
               cmd.emit_erase = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/cflw_dpath.sv
// ----------------------------------------------------------------------------
// Circular flash log writer datapath
// Page buffer in eight byte-lane RAMs, pointers, address generation and the
// output register.
// ----------------------------------------------------------------------------
module cflw_dpath import cflw_pkg::*; #(
   parameter int PAGE_BYTES       = 256,
   parameter int PAGES_PER_SECTOR = 16,
   parameter int SECTOR_BYTES     = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  cflw_cmd_type      cmd,
   output cflw_stat_type     stat,
   input  logic [BYTE_W-1:0] req_text_byte,
   input  logic              req_string_end,
   input  logic              csr_write,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [SEC_W-1:0]  csr_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_command,
   output logic [ADDR_W-1:0] rsp_flash_address,
   output logic [DATA_W-1:0] rsp_data_word,
   output logic              rsp_final_result
);

   localparam int WORDS  = PAGE_BYTES / 8;
   localparam int ROW_W  = $clog2(WORDS);
   localparam int FILL_W = $clog2(PAGE_BYTES + 1);
   localparam int PG_W   = ($clog2(PAGES_PER_SECTOR) > SPAGE_W) ?
                           $clog2(PAGES_PER_SECTOR) : SPAGE_W;
   localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(PAGE_BYTES);
   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(WORDS - 1);
   localparam logic [PG_W:0]     PG_LIMIT  = (PG_W + 1)'(PAGES_PER_SECTOR);
   localparam logic [ADDR_W-1:0] SEC_SCALE = ADDR_W'(SECTOR_BYTES);
   localparam logic [ADDR_W-1:0] PG_SCALE  = ADDR_W'(PAGE_BYTES);

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [ROW_W-1:0]  word_ff, word_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [SEC_W-1:0]  first_ff, first_in;
   logic [SEC_W-1:0]  last_ff, last_in;
   logic [SEC_W-1:0]  sector_ff, sector_in;
   logic [PG_W-1:0]   page_ff, page_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_command_ff, rsp_command_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_final_ff, rsp_final_in;

   logic              room;
   logic [FILL_W-1:0] fill_next;
   logic [PG_W:0]     page_inc;
   logic [SEC_W-1:0]  sector_inc;
   logic [SEC_W-1:0]  erase_target;
   logic [ADDR_W-1:0] base_addr;
   logic [ADDR_W-1:0] erase_addr;
   logic [DATA_W-1:0] page_word;

   assign room      = (fill_ff < FILL_MAX);
   assign fill_next = room ? fill_ff + FILL_W'(1) : fill_ff;
   assign page_inc  = {1'b0, page_ff} + (PG_W + 1)'(1);
   assign sector_inc = sector_ff + SEC_W'(1);

   assign stat.flush     = req_string_end &&
                           ((fill_next >= FILL_MAX) || (req_text_byte == NL_CHAR));
   assign stat.slot_free = !rsp_valid_ff || rsp_ready;
   assign stat.last_word = (word_ff == ROW_LAST);
   assign stat.page_wrap = (page_inc >= PG_LIMIT);

   assign base_addr    = ADDR_W'(sector_ff) * SEC_SCALE + ADDR_W'(page_ff) * PG_SCALE;
   assign erase_target = (sector_ff == last_ff) ? first_ff : sector_inc;
   assign erase_addr   = ADDR_W'(erase_target) * SEC_SCALE;

   // Eight byte lanes; lane b holds page bytes 8*row+b. Bytes at or past the
   // fill count read as zero.
   for (genvar b = 0; b < 8; b++) begin : g_lane
      logic [BYTE_W-1:0] lane_data;
      logic              lane_we;
      logic              lane_live;

      assign lane_we   = cmd.accept && room && (fill_ff[2:0] == 3'(b));
      assign lane_live = (FILL_W'({word_ff, 3'(b)}) < fill_ff);

      cflw_ram #(
         .WIDTH (BYTE_W),
         .DEPTH (WORDS)
      ) u_lane_ram (
         .clock   (clock),
         .wr_en   (lane_we),
         .wr_addr (ROW_W'(fill_ff >> 3)),
         .wr_data (req_text_byte),
         .rd_addr (word_ff),
         .rd_data (lane_data)
      );

      assign page_word[BYTE_W*b +: BYTE_W] = lane_live ? lane_data : '0;
   end

   always_comb begin
      fill_in   = fill_ff;
      word_in   = word_ff;
      addr_in   = addr_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      sector_in = sector_ff;
      page_in   = page_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_FIRST_SECTOR: first_in  = csr_data;
            CSR_LAST_SECTOR:  last_in   = csr_data;
            CSR_START_SECTOR: sector_in = csr_data;
            CSR_START_PAGE:   page_in   = PG_W'(csr_data[SPAGE_W-1:0]);
            default: ;
         endcase
      end

      if (cmd.accept) begin
         fill_in = fill_next;
      end
      if (cmd.load_base) begin
         addr_in = base_addr;
         word_in = '0;
      end
      if (cmd.emit_word) begin
         if (stat.last_word) begin
            fill_in = '0;
            page_in = stat.page_wrap ? '0 : page_inc[PG_W-1:0];
         end else begin
            word_in = word_ff + ROW_W'(1);
            addr_in = addr_ff + ADDR_W'(8);
         end
      end
      if (cmd.adv_sector) begin
         sector_in = (sector_ff >= last_ff) ? first_ff : sector_inc;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_command_in = rsp_command_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_final_in   = rsp_final_ff;
      if (cmd.emit_word) begin
         rsp_valid_in   = 1'b1;
         rsp_command_in = CMD_PROGRAM;
         rsp_addr_in    = addr_ff;
         rsp_data_in    = page_word;
         rsp_final_in   = stat.last_word && !stat.page_wrap;
      end else if (cmd.emit_erase) begin
         rsp_valid_in   = 1'b1;
         rsp_command_in = CMD_ERASE;
         rsp_addr_in    = erase_addr;
         rsp_data_in    = '0;
         rsp_final_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         first_ff     <= '0;
         last_ff      <= '1;
         sector_ff    <= '0;
         page_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         sector_ff    <= sector_in;
         page_ff      <= page_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff        <= word_in;
      addr_ff        <= addr_in;
      rsp_command_ff <= rsp_command_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_final_ff   <= rsp_final_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_command       = rsp_command_ff;
   assign rsp_flash_address = rsp_addr_ff;
   assign rsp_data_word     = rsp_data_ff;
   assign rsp_final_result  = rsp_final_ff;

   // The fill count saturates at one page.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("page fill count beyond one page");

   // The last program word of a page empties the buffer.
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_word && stat.last_word |=> fill_ff == '0)
      else $error("buffer not emptied after flush");

   // An erase is always the closing beat of its item.
   a_erase_final: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_erase |=> rsp_valid_ff && rsp_final_ff && rsp_command_ff == CMD_ERASE)
      else $error("erase beat not presented as final");

endmodule

FILE: design/circular_flash_log_writer_top.sv
// ----------------------------------------------------------------------------
// Circular flash log writer
// Collects log bytes into a flash page and writes full or newline-terminated
// pages as 64-bit program commands, erasing ahead round a ring of sectors.
// ----------------------------------------------------------------------------
// Usage. Log text enters on req_if, one byte per beat, with string_end set on
// the last byte of each string. Flash commands leave on rsp_if: a program of
// eight bytes (little endian, unused page bytes zero) or a sector erase, with
// final_result set on the last beat caused by an input beat. Registers on
// csr_if (first sector, last sector, start sector, start page) are to be
// written by the user only while the block is idle; the block itself does
// not enforce this. csr_if is always ready.
// Sequence. A byte that does not close a page is taken while idle and gives
// no result. A byte that closes a page leads to a page base load, then for
// each program word a page RAM read and an output load, and, when the sector
// wraps, a sector advance and an erase. The flush goes word by word as the
// page RAM has a single read port and the output register holds one word.
// New input is refused until the last beat of a flush has been loaded into
// the output register. Reset clears the page fill, sets the pointers to
// sector 0 page 0 and the ring to sectors 0 to 4095. When the receiver
// stalls, the output register holds its beat and the flush sequence waits.
// ----------------------------------------------------------------------------
module circular_flash_log_writer_top import cflw_pkg::*; #(
   parameter int PAGE_BYTES       = 256,
   parameter int PAGES_PER_SECTOR = 16,
   parameter int SECTOR_BYTES     = 4096
) (
   input logic        clock,
   input logic        reset,
   cflw_req_if.sink   req_if,
   cflw_rsp_if.source rsp_if,
   cflw_csr_if.sink   csr_if
);

   cflw_cmd_type  cmd;
   cflw_stat_type stat;

   // Register writes never stall.
   assign csr_if.ready = 1'b1;

   // The controller owns the input handshake and sequences the datapath.
   cflw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the page, the pointers and the output register.
   cflw_dpath #(
      .PAGE_BYTES       (PAGE_BYTES),
      .PAGES_PER_SECTOR (PAGES_PER_SECTOR),
      .SECTOR_BYTES     (SECTOR_BYTES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_text_byte     (req_if.text_byte),
      .req_string_end    (req_if.string_end),
      .csr_write         (csr_if.valid),
      .csr_index         (csr_if.index),
      .csr_data          (csr_if.data),
      .rsp_valid         (rsp_if.valid),
      .rsp_ready         (rsp_if.ready),
      .rsp_command       (rsp_if.command),
      .rsp_flash_address (rsp_if.flash_address),
      .rsp_data_word     (rsp_if.data_word),
      .rsp_final_result  (rsp_if.final_result)
   );

endmodule
